FILE: sv/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared constants and codes for the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int MaxRun = 16;

   localparam int DeadlineWidth = 32;
   localparam int TagWidth = 16;
   localparam int DelayWidth = 16;
   localparam int EntryWidth = DeadlineWidth + TagWidth + DelayWidth;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_EXPIRED = 2'd2;

endpackage

FILE: sv/sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Deadline-sorted alarm list held in a circular RAM buffer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Word
// req      in         req_valid / req_stall  type, delay ticks, alarm tag
// rsp      out        rsp_valid / rsp_stall  kind, tag, delay, last of run
//
// A zero-delay or rejected insert is answered without a RAM access. An accepted
// insert moves each later stored entry down the list by a read-compare-write
// walk through the single RAM read port.
// A tick removes and reports the expired alarms from the head of the list.
// Reset clears the count, head pointer and time; RAM contents are not cleared.
// A stalled result holds the sequencer until it is taken.
module sorted_alarm_timer_queue #(
   parameter int QUEUE_DEPTH = sat_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_delay_ticks,
   input  logic [15:0] req_alarm_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_result_tag,
   output logic [15:0] rsp_result_delay,
   output logic        rsp_last_of_run
);
   import sat_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = $clog2(MaxRun + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS_RD = 3'd1;
   localparam logic [2:0] S_INS_CMP = 3'd2;
   localparam logic [2:0] S_INS_WR = 3'd3;
   localparam logic [2:0] S_TK_RD = 3'd4;
   localparam logic [2:0] S_TK_CMP = 3'd5;
   localparam logic [2:0] S_TK_END = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [DeadlineWidth-1:0] time_ff, time_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [NW-1:0]            run_ff, run_in;
   logic [DeadlineWidth-1:0] dl_ff, dl_in;
   logic [TagWidth-1:0]      tag_ff, tag_in;
   logic [DelayWidth-1:0]    delay_ff, delay_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [TagWidth-1:0]      pend_tag_ff, pend_tag_in;
   logic [DelayWidth-1:0]    pend_delay_ff, pend_delay_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic [TagWidth-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [DelayWidth-1:0]    rsp_delay_ff, rsp_delay_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [EntryWidth-1:0] wr_data, rd_data;
   logic [DeadlineWidth-1:0] q_dl;
   logic [TagWidth-1:0]      q_tag;
   logic [DelayWidth-1:0]    q_delay;
   logic                  rsp_free, accept;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] ofs);
      logic [AW+CW:0] sum;
      sum = {{(CW+1){1'b0}}, head} + {{(AW+1){1'b0}}, ofs};
      if (sum >= (AW+CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (AW+CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   sat_ram #(
      .WIDTH(EntryWidth),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign q_dl = rd_data[EntryWidth-1 -: DeadlineWidth];
   assign q_tag = rd_data[DelayWidth +: TagWidth];
   assign q_delay = rd_data[DelayWidth-1:0];

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      head_in = head_ff;
      time_in = time_ff;
      idx_in = idx_ff;
      run_in = run_ff;
      dl_in = dl_ff;
      tag_in = tag_ff;
      delay_in = delay_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in = pend_tag_ff;
      pend_delay_in = pend_delay_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_delay_in = rsp_delay_ff;
      rsp_last_in = rsp_last_ff;
      wr_en = 1'b0;
      wr_addr = phys(head_ff, idx_ff);
      wr_data = {dl_ff, tag_ff, delay_ff};
      rd_en = 1'b0;
      rd_addr = phys(head_ff, idx_ff - CW'(1));

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == REQ_TICK) begin
                  time_in = time_ff + DeadlineWidth'(1);
                  run_in = '0;
                  pend_valid_in = 1'b0;
                  state_in = S_TK_RD;
               end else if (req_delay_ticks == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in = KIND_EXPIRED;
                  rsp_tag_in = req_alarm_tag;
                  rsp_delay_in = '0;
                  rsp_last_in = 1'b1;
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in = KIND_REJECTED;
                  rsp_tag_in = req_alarm_tag;
                  rsp_delay_in = req_delay_ticks;
                  rsp_last_in = 1'b1;
               end else begin
                  dl_in = time_ff + {{(DeadlineWidth-DelayWidth){1'b0}}, req_delay_ticks};
                  tag_in = req_alarm_tag;
                  delay_in = req_delay_ticks;
                  idx_in = count_ff;
                  state_in = (count_ff == '0) ? S_INS_WR : S_INS_RD;
               end
            end
         end
         S_INS_RD: begin
            rd_en = 1'b1;
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (q_dl >= dl_ff) begin
               wr_en = 1'b1;
               wr_data = rd_data;
               idx_in = idx_ff - CW'(1);
               state_in = (idx_ff == CW'(1)) ? S_INS_WR : S_INS_RD;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            if (rsp_free) begin
               wr_en = 1'b1;
               count_in = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_ACCEPTED;
               rsp_tag_in = tag_ff;
               rsp_delay_in = delay_ff;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TK_RD: begin
            if (count_ff != '0 && run_ff < NW'(MaxRun)) begin
               rd_en = 1'b1;
               rd_addr = head_ff;
               state_in = S_TK_CMP;
            end else begin
               state_in = S_TK_END;
            end
         end
         S_TK_CMP: begin
            if (q_dl <= time_ff) begin
               if (!pend_valid_ff || rsp_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in = KIND_EXPIRED;
                     rsp_tag_in = pend_tag_ff;
                     rsp_delay_in = pend_delay_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_tag_in = q_tag;
                  pend_delay_in = q_delay;
                  head_in = phys(head_ff, CW'(1));
                  count_in = count_ff - CW'(1);
                  run_in = run_ff + NW'(1);
                  state_in = S_TK_RD;
               end
            end else begin
               state_in = S_TK_END;
            end
         end
         S_TK_END: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_EXPIRED;
               rsp_tag_in = pend_tag_ff;
               rsp_delay_in = pend_delay_ff;
               rsp_last_in = 1'b1;
               pend_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff <= '0;
         time_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff <= head_in;
         time_ff <= time_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      run_ff <= run_in;
      dl_ff <= dl_in;
      tag_ff <= tag_in;
      delay_ff <= delay_in;
      pend_tag_ff <= pend_tag_in;
      pend_delay_ff <= pend_delay_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_delay_ff <= rsp_delay_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_result_tag = rsp_tag_ff;
   assign rsp_result_delay = rsp_delay_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

FILE: sv/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
